@@ hw/rtl/tspr_pkg.sv @@
`default_nettype none
package tspr_pkg;

  localparam int PoolSlotsDefault  = 128;
  localparam int QueueCountDefault = 4;

  localparam int ReqW    = 3;
  localparam int QidW    = 2;
  localparam int StatusW = 3;
  localparam int SlotW   = 7;
  localparam int CountW  = 8;

  typedef enum logic [ReqW-1:0] {
    REQ_SORTED   = 3'd0,
    REQ_NODUP    = 3'd1,
    REQ_WORD     = 3'd2,
    REQ_PUSH_HD  = 3'd3,
    REQ_PUSH_TL  = 3'd4,
    REQ_POP_HD   = 3'd5,
    REQ_POP_TL   = 3'd6,
    REQ_BAD      = 3'd7
  } req_t;

  typedef enum logic [StatusW-1:0] {
    ST_INSERTED = 3'd0,
    ST_REPLACED = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_REMOVED  = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_FULL     = 3'd5,
    ST_INVALID  = 3'd6,
    ST_SPARE    = 3'd7
  } status_t;

  // record payload kept per slot
  typedef struct packed {
    logic [15:0] rti_word;
    logic [15:0] fill_length;
    logic [7:0]  rti;
    logic [31:0] sclk;
  } rec_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TOP,
    S_WALK_RD,
    S_WALK_CMP,
    S_POP_RD,
    S_POP_FIX,
    S_INS_FIX,
    S_REP_RD,
    S_REP_FIX,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

@@ hw/rtl/tspr_slot_mem.sv @@
`default_nettype none
// record and link store, one shared read address and one write port per memory, registered read
module tspr_slot_mem #(
  parameter int PoolSlots = tspr_pkg::PoolSlotsDefault,
  parameter int IdxW      = $clog2(PoolSlots)
) (
  input  wire logic           clk,
  input  wire logic [IdxW-1:0] rd_addr,
  output      tspr_pkg::rec_t  rd_rec,
  output      logic [IdxW-1:0] rd_next,
  output      logic [IdxW-1:0] rd_prev,
  input  wire logic           wr_rec_en,
  input  wire logic [IdxW-1:0] wr_rec_addr,
  input  wire tspr_pkg::rec_t  wr_rec,
  input  wire logic           wr_next_en,
  input  wire logic [IdxW-1:0] wr_next_addr,
  input  wire logic [IdxW-1:0] wr_next_data,
  input  wire logic           wr_prev_en,
  input  wire logic [IdxW-1:0] wr_prev_addr,
  input  wire logic [IdxW-1:0] wr_prev_data
);
  import tspr_pkg::*;

  rec_t            rec_mem  [PoolSlots];
  logic [IdxW-1:0] next_mem [PoolSlots];
  logic [IdxW-1:0] prev_mem [PoolSlots];

  // record memory
  always_ff @(posedge clk) begin
    if (wr_rec_en) rec_mem[wr_rec_addr] <= wr_rec;
    rd_rec <= rec_mem[rd_addr];
  end

  // forward links
  always_ff @(posedge clk) begin
    if (wr_next_en) next_mem[wr_next_addr] <= wr_next_data;
    rd_next <= next_mem[rd_addr];
  end

  // backward links
  always_ff @(posedge clk) begin
    if (wr_prev_en) prev_mem[wr_prev_addr] <= wr_prev_data;
    rd_prev <= prev_mem[rd_addr];
  end
endmodule
`default_nettype wire

@@ hw/rtl/tspr_free_stack.sv @@
`default_nettype none
// free slot stack: memory filled by a sweep after reset, top cached
module tspr_free_stack #(
  parameter int PoolSlots = tspr_pkg::PoolSlotsDefault,
  parameter int IdxW      = $clog2(PoolSlots),
  parameter int CntW      = $clog2(PoolSlots + 1)
) (
  input  wire logic            clk,
  input  wire logic            rst,
  output      logic            ready,
  output      logic [CntW-1:0] count,
  output      logic [IdxW-1:0] top,
  input  wire logic            pop,
  input  wire logic            push,
  input  wire logic [IdxW-1:0] push_slot
);
  import tspr_pkg::*;

  logic [IdxW-1:0] mem [PoolSlots];
  logic [CntW-1:0] fill;
  logic            top_valid;
  logic [IdxW-1:0] rd_data;
  logic            rd_pend;

  assign ready = (fill == CntW'(PoolSlots)) && top_valid && !rd_pend;

  // init sweep, push/pop with refill of the cached top
  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      count     <= CntW'(PoolSlots);
      top_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      rd_pend <= 1'b0;
      if (fill != CntW'(PoolSlots)) begin
        mem[fill[IdxW-1:0]] <= fill[IdxW-1:0];
        fill <= fill + CntW'(1);
        if (fill == CntW'(PoolSlots - 1)) begin
          top       <= fill[IdxW-1:0];
          top_valid <= 1'b1;
        end
      end else if (rd_pend) begin
        top <= rd_data;
      end else if (push && pop) begin
        // swap the top entry, count unchanged
        mem[IdxW'(count - CntW'(1))] <= push_slot;
        top <= push_slot;
      end else if (push && count < CntW'(PoolSlots)) begin
        mem[count[IdxW-1:0]] <= push_slot;
        top   <= push_slot;
        count <= count + CntW'(1);
      end else if (pop && count != '0) begin
        count <= count - CntW'(1);
        if (count > CntW'(1)) rd_pend <= 1'b1;
      end
    end
  end

  // entry below the top, ready as the new top after a pop
  always_ff @(posedge clk) begin
    rd_data <= mem[IdxW'(count - CntW'(2))];
  end
endmodule
`default_nettype wire

@@ hw/rtl/time_sorted_packet_reorder_queues.sv @@
`default_nettype none
// Time-sorted reorder queues over a shared pool of record slots. One request
// is taken at a time and gives one result; the next request is taken only
// after the result transfer. Sorted inserts walk the addressed queue from its
// head, reading one slot at a time through the record memory. After reset the
// free-slot stack is filled by a sweep over all PoolSlots entries during which
// no request is accepted.
module time_sorted_packet_reorder_queues #(
  parameter int PoolSlots  = tspr_pkg::PoolSlotsDefault,
  parameter int QueueCount = tspr_pkg::QueueCountDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output      logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // req_type, queue_id, sclk, rti, fill_length, rti_word from bit 0 up
  input  wire logic [79:0] s_axis_tdata,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status, slot, freed_slot, queue_count, out_sclk, out_rti,
  // out_fill_length, out_rti_word from bit 0 up
  output      logic [103:0] m_axis_tdata
);
  import tspr_pkg::*;

  localparam int IdxW = $clog2(PoolSlots);
  localparam int CntW = $clog2(PoolSlots + 1);
  localparam int QW   = (QueueCount > 1) ? $clog2(QueueCount) : 1;

  state_t state, state_next;

  logic [15:0] rti_offset;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) rti_offset <= '0;
    else if (cfg_valid) rti_offset <= cfg_data;
  end

  // request registers
  req_t            req;
  logic [QidW-1:0] qid;
  rec_t            nrec;
  logic [QW-1:0]   q;

  // per queue head, tail and size
  logic [IdxW-1:0] q_first [QueueCount];
  logic [IdxW-1:0] q_last  [QueueCount];
  logic [CntW-1:0] q_size  [QueueCount];

  // walk state
  logic [IdxW-1:0] cur;
  logic [CntW-1:0] steps;
  logic            found, dup;
  logic [IdxW-1:0] at;
  logic [IdxW-1:0] at_prev, at_next;
  rec_t            at_rec;
  logic            pop_first, pop_last;

  // result
  status_t         r_status;
  logic [IdxW-1:0] r_slot, r_freed;
  rec_t            r_rec;

  // memory ports
  logic [IdxW-1:0] rd_addr;
  rec_t            rd_rec;
  logic [IdxW-1:0] rd_next, rd_prev;
  logic            wr_rec_en, wr_next_en, wr_prev_en;
  logic [IdxW-1:0] wr_next_addr, wr_next_data, wr_prev_addr, wr_prev_data;

  logic            fs_ready, fs_pop, fs_push;
  logic [CntW-1:0] fs_count;
  logic [IdxW-1:0] fs_top, fs_push_slot;

  // second write port mux onto the link memories
  logic            mx_next_en, mx_prev_en;
  logic [IdxW-1:0] mx_next_addr, mx_prev_addr, mx_next_data, mx_prev_data;

  tspr_slot_mem #(.PoolSlots(PoolSlots), .IdxW(IdxW)) u_mem (
    .clk, .rd_addr, .rd_rec, .rd_next, .rd_prev,
    .wr_rec_en, .wr_rec_addr(fs_top), .wr_rec(nrec),
    .wr_next_en(mx_next_en), .wr_next_addr(mx_next_addr), .wr_next_data(mx_next_data),
    .wr_prev_en(mx_prev_en), .wr_prev_addr(mx_prev_addr), .wr_prev_data(mx_prev_data)
  );

  tspr_free_stack #(.PoolSlots(PoolSlots), .IdxW(IdxW), .CntW(CntW)) u_free (
    .clk, .rst, .ready(fs_ready), .count(fs_count), .top(fs_top),
    .pop(fs_pop), .push(fs_push), .push_slot(fs_push_slot)
  );

  logic q_ok;
  assign q_ok = (32'(qid) < 32'(QueueCount));

  // key compare of the read slot against the new record
  logic        c_gt, c_eq;
  logic [15:0] ka, kb;
  always_comb begin
    ka = rd_rec.rti_word + rti_offset;
    kb = nrec.rti_word + rti_offset;
    if (req == REQ_WORD) begin
      c_gt = ka > kb;
      c_eq = ka == kb;
    end else begin
      c_gt = {rd_rec.sclk, rd_rec.rti} > {nrec.sclk, nrec.rti};
      c_eq = {rd_rec.sclk, rd_rec.rti} == {nrec.sclk, nrec.rti};
    end
  end

  assign s_axis_tready = (state == S_IDLE) && fs_ready;

  // next state and memory controls
  always_comb begin
    state_next   = state;
    rd_addr      = cur;
    wr_rec_en    = 1'b0;
    wr_next_en   = 1'b0;
    wr_prev_en   = 1'b0;
    wr_next_addr = fs_top;
    wr_next_data = '0;
    wr_prev_addr = fs_top;
    wr_prev_data = '0;
    fs_pop       = 1'b0;
    fs_push      = 1'b0;
    fs_push_slot = at;
    unique case (state)
      S_IDLE: if (s_axis_tvalid && s_axis_tready) state_next = S_TOP;
      S_TOP: begin
        if (req == REQ_BAD || !q_ok) state_next = S_DONE;
        else if (req == REQ_POP_HD || req == REQ_POP_TL) begin
          rd_addr = (req == REQ_POP_HD) ? q_first[q] : q_last[q];
          state_next = (q_size[q] == '0) ? S_DONE : S_POP_RD;
        end else if (fs_count == '0) state_next = S_DONE;
        else if (req == REQ_PUSH_HD || req == REQ_PUSH_TL) state_next = S_INS_FIX;
        else state_next = S_WALK_RD;
      end
      S_WALK_RD: state_next = (steps == '0) ? S_INS_FIX : S_WALK_CMP;
      S_WALK_CMP: begin
        if (req == REQ_NODUP && c_eq) state_next = S_REP_RD;
        else if (c_gt) state_next = S_INS_FIX;
        else state_next = S_WALK_RD;
      end
      S_POP_RD: begin
        state_next = S_POP_FIX;
        fs_push = 1'b1;
        fs_push_slot = at;
      end
      S_POP_FIX: begin
        // repair neighbor links of the removed slot
        if (!pop_first) begin
          wr_next_en = 1'b1; wr_next_addr = at_prev; wr_next_data = at_next;
        end
        if (!pop_last) begin
          wr_prev_en = 1'b1; wr_prev_addr = at_next; wr_prev_data = at_prev;
        end
        state_next = S_DONE;
      end
      S_REP_RD: state_next = (at_rec.fill_length > nrec.fill_length) ? S_DONE : S_REP_FIX;
      S_REP_FIX: begin
        // new slot off the stack, replaced slot back on it
        wr_rec_en = 1'b1;
        fs_pop = 1'b1;
        fs_push = 1'b1;
        fs_push_slot = at;
        wr_next_en = 1'b1; wr_next_data = at_next;
        wr_prev_en = 1'b1; wr_prev_data = at_prev;
        state_next = S_DONE;
      end
      S_INS_FIX: begin
        wr_rec_en = 1'b1;
        fs_pop = 1'b1;
        state_next = S_DONE;
        if (q_size[q] != '0) begin
          if (found) begin
            wr_next_en = 1'b1; wr_next_data = at;
            wr_prev_en = 1'b1; wr_prev_data = at_prev;
          end else if (req == REQ_PUSH_HD) begin
            wr_next_en = 1'b1; wr_next_data = q_first[q];
            wr_prev_en = 1'b1; wr_prev_addr = q_first[q]; wr_prev_data = fs_top;
          end else begin
            wr_prev_en = 1'b1; wr_prev_data = q_last[q];
            wr_next_en = 1'b1; wr_next_addr = q_last[q]; wr_next_data = fs_top;
          end
        end
      end
      S_DONE: if (m_axis_tvalid && m_axis_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // second link write for the middle insert and replacement
  logic            fix2, fix2_is_next;
  logic [IdxW-1:0] fix2_addr, fix2_data;
  logic [IdxW-1:0] wr2_addr;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QueueCount; i++) q_size[i] <= '0;
      m_axis_tvalid <= 1'b0;
      fix2 <= 1'b0;
      dup <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (s_axis_tvalid && s_axis_tready) begin
          req  <= req_t'(s_axis_tdata[2:0]);
          qid  <= s_axis_tdata[4:3];
          q    <= QW'(s_axis_tdata[4:3]);
          nrec <= rec_t'({s_axis_tdata[76:61], s_axis_tdata[60:45],
                          s_axis_tdata[44:37], s_axis_tdata[36:5]});
          found <= 1'b0;
          r_slot <= '0; r_freed <= '0; r_rec <= '0;
        end
        S_TOP: begin
          cur   <= q_first[q];
          steps <= q_size[q];
          at    <= (req == REQ_POP_HD) ? q_first[q] : q_last[q];
          if (req == REQ_BAD || !q_ok) r_status <= ST_INVALID;
          else if (req == REQ_POP_HD || req == REQ_POP_TL) begin
            if (q_size[q] == '0) r_status <= ST_EMPTY;
          end else if (fs_count == '0) r_status <= ST_FULL;
        end
        S_WALK_RD: ;
        S_WALK_CMP: begin
          at <= cur; at_prev <= rd_prev; at_next <= rd_next; at_rec <= rd_rec;
          if (req == REQ_NODUP && c_eq) ;
          else if (c_gt) found <= 1'b1;
          else begin
            cur <= rd_next;
            steps <= steps - CntW'(1);
          end
        end
        S_POP_RD: begin
          at_prev <= rd_prev; at_next <= rd_next;
          r_rec <= rd_rec; r_slot <= at; r_status <= ST_REMOVED;
          q_size[q] <= q_size[q] - CntW'(1);
          pop_first <= (at == q_first[q]);
          pop_last  <= (at == q_last[q]);
          if (at == q_first[q]) q_first[q] <= rd_next;
          if (at == q_last[q])  q_last[q]  <= rd_prev;
        end
        S_POP_FIX: ;
        S_REP_RD: begin
          if (at_rec.fill_length > nrec.fill_length) begin
            r_status <= ST_DROPPED; r_slot <= at;
          end
        end
        S_REP_FIX: begin
          r_status <= ST_REPLACED; r_slot <= fs_top; r_freed <= at;
          if (at == q_first[q]) q_first[q] <= fs_top;
          else begin fix2 <= 1'b1; fix2_is_next <= 1'b1; fix2_addr <= at_prev; end
          if (at == q_last[q]) q_last[q] <= fs_top;
          fix2_data <= fs_top;
          wr2_addr <= at_next;
          if (at != q_last[q]) begin
            if (at == q_first[q]) begin
              fix2 <= 1'b1; fix2_is_next <= 1'b0; fix2_addr <= at_next;
            end
          end
          dup <= (at != q_first[q]) && (at != q_last[q]);
        end
        S_INS_FIX: begin
          r_status <= ST_INSERTED; r_slot <= fs_top;
          q_size[q] <= q_size[q] + CntW'(1);
          fix2_data <= fs_top;
          dup <= (q_size[q] != '0) && found;
          if (q_size[q] == '0) begin
            q_first[q] <= fs_top; q_last[q] <= fs_top;
          end else if (found) begin
            if (at == q_first[q]) q_first[q] <= fs_top;
            else begin fix2 <= 1'b1; fix2_is_next <= 1'b1; fix2_addr <= at_prev; end
            wr2_addr <= at;
          end else if (req == REQ_PUSH_HD) q_first[q] <= fs_top;
          else q_last[q] <= fs_top;
        end
        S_DONE: begin
          // pending link writes end with the first cycle here
          fix2 <= 1'b0;
          dup  <= 1'b0;
          if (!m_axis_tvalid) m_axis_tvalid <= 1'b1;
          else if (m_axis_tready) m_axis_tvalid <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // pending link writes issued in the cycle after the fix state
  logic            late_next_en, late_prev_en;
  logic [IdxW-1:0] late_next_addr, late_prev_addr, late_data;
  always_comb begin
    late_next_en   = fix2 && fix2_is_next;
    late_prev_en   = (fix2 && !fix2_is_next) || (dup && state == S_DONE && !m_axis_tvalid);
    late_next_addr = fix2_addr;
    late_prev_addr = (fix2 && !fix2_is_next) ? fix2_addr : wr2_addr;
    late_data      = fix2_data;
  end

  always_comb begin
    mx_next_en = wr_next_en || late_next_en;
    mx_next_addr = late_next_en ? late_next_addr : wr_next_addr;
    mx_next_data = late_next_en ? late_data : wr_next_data;
    mx_prev_en = wr_prev_en || late_prev_en;
    mx_prev_addr = late_prev_en ? late_prev_addr : wr_prev_addr;
    mx_prev_data = late_prev_en ? late_data : wr_prev_data;
  end

  assign m_axis_tdata = {7'b0,
    r_rec.rti_word, r_rec.fill_length, r_rec.rti, r_rec.sclk,
    (r_status == ST_INVALID) ? 8'd0 : 8'(q_size[q]),
    7'(r_freed), 7'(r_slot), r_status};
endmodule
`default_nettype wire

@@ tb/time_sorted_packet_reorder_queues_chk.sv @@
`default_nettype none
module time_sorted_packet_reorder_queues_chk #(
  parameter int PoolSlots  = 128,
  parameter int QueueCount = 4
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [79:0]  s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [103:0] m_axis_tdata,
  output int                errors,
  output int                pending
);
  import tspr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t     status;
    logic [6:0]  slot;
    logic [6:0]  freed;
    logic [7:0]  count;
    logic [31:0] sclk;
    logic [7:0]  rti;
    logic [15:0] fill;
    logic [15:0] word;
  } outcome_t;

  // mirrored pool contents and links
  logic [31:0] rec_sclk [PoolSlots];
  logic [7:0]  rec_rti  [PoolSlots];
  logic [15:0] rec_fill [PoolSlots];
  logic [15:0] rec_word [PoolSlots];
  int          nxt      [PoolSlots];
  int          prv      [PoolSlots];
  int          head_of  [QueueCount];
  int          tail_of  [QueueCount];
  int          depth    [QueueCount];
  int          free_slots [PoolSlots];
  int          free_top;
  logic [15:0] word_bias;
  outcome_t    awaited [$];

  // -1, 0, 1 as stored record key is below, equal, above the new one
  function automatic int key_order(int e, req_t mode, logic [31:0] sclk,
                                   logic [7:0] rti, logic [15:0] word);
    logic [15:0] a, b;
    a = rec_word[e] + word_bias;
    b = word + word_bias;
    if (mode == REQ_WORD) return (a > b) ? 1 : ((a < b) ? -1 : 0);
    if (rec_sclk[e] != sclk) return (rec_sclk[e] > sclk) ? 1 : -1;
    if (rec_rti[e] != rti) return (rec_rti[e] > rti) ? 1 : -1;
    return 0;
  endfunction

  task automatic unlink(int q, int s);
    if (s == head_of[q]) head_of[q] = nxt[s];
    else nxt[prv[s]] = nxt[s];
    if (s == tail_of[q]) tail_of[q] = prv[s];
    else prv[nxt[s]] = prv[s];
    depth[q]--;
  endtask

  // work out the outcome of one request and update the mirror
  task automatic service(input logic [79:0] d);
    req_t        req;
    int          q, s, at, cur, c;
    bit          found, dup;
    logic [31:0] sclk;
    logic [7:0]  rti;
    logic [15:0] fill, word;
    outcome_t    r;
    req  = req_t'(d[2:0]);
    q    = int'(d[4:3]);
    sclk = d[36:5];
    rti  = d[44:37];
    fill = d[60:45];
    word = d[76:61];
    r = '0;
    r.status = ST_INVALID;
    found = 0;
    dup = 0;
    at = 0;
    if (req != REQ_BAD && q < QueueCount) begin
      if (req == REQ_POP_HD || req == REQ_POP_TL) begin
        if (depth[q] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          s = (req == REQ_POP_HD) ? head_of[q] : tail_of[q];
          unlink(q, s);
          r.sclk = rec_sclk[s];
          r.rti = rec_rti[s];
          r.fill = rec_fill[s];
          r.word = rec_word[s];
          free_slots[free_top++] = s;
          r.slot = 7'(s);
          r.status = ST_REMOVED;
        end
      end else if (free_top == 0) begin
        r.status = ST_FULL;
      end else begin
        s = free_slots[free_top-1];
        if (req == REQ_SORTED || req == REQ_NODUP || req == REQ_WORD) begin
          cur = head_of[q];
          for (int i = 0; i < depth[q]; i++) begin
            c = key_order(cur, req, sclk, rti, word);
            if (req == REQ_NODUP && c == 0) begin
              dup = 1;
              at = cur;
              break;
            end
            if (c > 0) begin
              found = 1;
              at = cur;
              break;
            end
            cur = nxt[cur];
          end
        end
        if (dup && rec_fill[at] > fill) begin
          r.status = ST_DROPPED;
          r.slot = 7'(at);
        end else begin
          free_top--;
          rec_sclk[s] = sclk;
          rec_rti[s] = rti;
          rec_fill[s] = fill;
          rec_word[s] = word;
          r.slot = 7'(s);
          r.status = ST_INSERTED;
          if (dup) begin
            // new record takes over the old one's links
            nxt[s] = nxt[at];
            prv[s] = prv[at];
            if (at == head_of[q]) head_of[q] = s;
            else nxt[prv[at]] = s;
            if (at == tail_of[q]) tail_of[q] = s;
            else prv[nxt[at]] = s;
            free_slots[free_top++] = at;
            r.freed = 7'(at);
            r.status = ST_REPLACED;
          end else if (found) begin
            nxt[s] = at;
            prv[s] = prv[at];
            if (at == head_of[q]) head_of[q] = s;
            else nxt[prv[at]] = s;
            prv[at] = s;
            depth[q]++;
          end else if (req == REQ_PUSH_HD) begin
            if (depth[q] == 0) tail_of[q] = s;
            else begin
              nxt[s] = head_of[q];
              prv[head_of[q]] = s;
            end
            head_of[q] = s;
            depth[q]++;
          end else begin
            if (depth[q] == 0) head_of[q] = s;
            else begin
              prv[s] = tail_of[q];
              nxt[tail_of[q]] = s;
            end
            tail_of[q] = s;
            depth[q]++;
          end
        end
      end
      r.count = 8'(depth[q]);
    end
    awaited.push_back(r);
  endtask

  task automatic compare_result(input logic [103:0] d);
    outcome_t a, e;
    a.status = status_t'(d[2:0]);
    a.slot   = d[9:3];
    a.freed  = d[16:10];
    a.count  = d[24:17];
    a.sclk   = d[56:25];
    a.rti    = d[64:57];
    a.fill   = d[80:65];
    a.word   = d[96:81];
    if (awaited.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result transfer: %p", a);
    end else begin
      e = awaited.pop_front();
      if (a.status != e.status || a.slot != e.slot || a.freed != e.freed ||
          a.count != e.count || a.sclk != e.sclk || a.rti != e.rti ||
          a.fill != e.fill || a.word != e.word) begin
        errors++;
        if (errors <= 10) $display("result mismatch at %0t\n  exp %p\n  act %p",
                                   $realtime, e, a);
      end
    end
  endtask

  // sample transfers at each edge
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PoolSlots; i++) begin
        free_slots[i] = i;
        nxt[i] = 0;
        prv[i] = 0;
      end
      for (int i = 0; i < QueueCount; i++) begin
        head_of[i] = 0;
        tail_of[i] = 0;
        depth[i] = 0;
      end
      free_top = PoolSlots;
      word_bias = '0;
      errors = 0;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) word_bias = cfg_data;
      if (s_axis_tvalid && s_axis_tready) service(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) compare_result(m_axis_tdata);
    end
    pending = awaited.size();
  end

endmodule
`default_nettype wire

@@ tb/time_sorted_packet_reorder_queues_tb.sv @@
`default_nettype none
module time_sorted_packet_reorder_queues_tb;
  import tspr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1000000;

  logic         clk = 0;
  logic         rst = 1;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [15:0]  cfg_data = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [79:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [103:0] m_axis_tdata;
  int           errors, pending;
  bit           hold_request = 0;
  int           burst_left = 0;

  time_sorted_packet_reorder_queues dut (.*);

  time_sorted_packet_reorder_queues_chk chk (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: own stall pattern plus one long hold-off on request
  initial begin
    int hold_cycles, phase;
    bit hold_used;
    hold_cycles = 0;
    hold_used = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      phase++;
      if (hold_request && !hold_used) begin
        hold_used = 1;
        hold_cycles = 700;
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        m_axis_tready <= 0;
      end else if ((phase / 64) % 3 == 0) begin
        m_axis_tready <= 1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // cycle limit
  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [79:0] pack_item(req_t req, int q, logic [31:0] sclk,
                                            logic [7:0] rti, logic [15:0] fill,
                                            logic [15:0] word);
    return {3'b0, word, fill, rti, sclk, q[1:0], req};
  endfunction

  // one request transfer, inside bursts with random gaps between them
  task automatic send(input logic [79:0] d);
    if (burst_left == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    burst_left--;
    if (burst_left == 0) s_axis_tvalid <= 0;
  endtask

  task automatic drain;
    s_axis_tvalid <= 0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_bias(input logic [15:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  // random request with clustered keys so duplicates and ties happen often
  function automatic logic [79:0] random_item(int insert_bias);
    req_t        req;
    int          pick;
    logic [31:0] sclk;
    logic [7:0]  rti;
    logic [15:0] word;
    pick = $urandom_range(0, 99);
    if (pick < insert_bias) req = req_t'($urandom_range(0, 4));
    else if (pick < 98) req = ($urandom_range(0, 1) != 0) ? REQ_POP_HD : REQ_POP_TL;
    else req = REQ_BAD;
    sclk = ($urandom_range(0, 3) == 0) ? $urandom : 32'(($urandom_range(0, 5)) << 28);
    rti = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
    word = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7) << 13);
    return pack_item(req, $urandom_range(0, 3), sclk, rti, 16'($urandom), word);
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 0;

    // directed: empty pops, bad request, ordering, duplicates, word mode, head and tail pushes and pops
    send(pack_item(REQ_POP_HD, 0, '0, '0, '0, '0));
    send(pack_item(REQ_POP_TL, 1, '0, '0, '0, '0));
    send(pack_item(REQ_BAD, 3, '1, '1, '1, '1));
    send(pack_item(REQ_SORTED, 0, '1, '1, '1, '1));
    send(pack_item(REQ_SORTED, 0, '0, '0, '0, '0));
    send(pack_item(REQ_SORTED, 0, 32'h100, 8'h80, 16'h10, 16'h1));
    send(pack_item(REQ_SORTED, 0, 32'h100, 8'h80, 16'h20, 16'h2));
    send(pack_item(REQ_NODUP, 1, 32'h55, 8'h7, 16'h100, 16'h3));
    send(pack_item(REQ_NODUP, 1, 32'h55, 8'h7, 16'h200, 16'h4));
    send(pack_item(REQ_NODUP, 1, 32'h55, 8'h7, 16'h200, 16'h5));
    send(pack_item(REQ_NODUP, 1, 32'h55, 8'h7, 16'h1ff, 16'h6));
    send(pack_item(REQ_NODUP, 1, 32'h54, 8'hff, 16'h0, 16'h7));
    send(pack_item(REQ_WORD, 2, '0, '0, '0, 16'hffff));
    send(pack_item(REQ_WORD, 2, '0, '0, '0, 16'h0000));
    send(pack_item(REQ_WORD, 2, '0, '0, '0, 16'h8000));
    send(pack_item(REQ_PUSH_HD, 3, 32'haaaa5555, 8'h5a, 16'h1234, 16'habcd));
    send(pack_item(REQ_PUSH_TL, 3, 32'h5555aaaa, 8'ha5, 16'hedcb, 16'h5432));
    for (int i = 0; i < 4; i++) begin
      send(pack_item(REQ_POP_HD, i, '0, '0, '0, '0));
      send(pack_item(REQ_POP_TL, i, '0, '0, '0, '0));
    end
    drain();

    // random traffic, word ordering with the largest offset
    write_bias(16'hffff);
    for (int i = 0; i < 250; i++) send(random_item(60));
    drain();

    // fill the pool to exhaustion while the receiver holds off
    write_bias(16'h8000);
    hold_request <= 1;
    for (int i = 0; i < 136; i++) begin
      if (i % 4 == 0) send(random_item(100));
      else send(pack_item(REQ_PUSH_TL, i % 4, 32'($urandom), 8'($urandom),
                          16'($urandom), 16'($urandom)));
    end
    for (int i = 0; i < 8; i++) send(random_item(100));
    for (int i = 0; i < 150; i++) send(random_item(5));
    drain();

    // back to no offset, balanced traffic
    write_bias(16'h0000);
    for (int i = 0; i < 150; i++) send(random_item(55));
    drain();
    write_bias(16'($urandom));
    for (int i = 0; i < 130; i++) send(random_item(50));
    drain();

    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
